// File: rtl/core/lzss_pkg.sv
package lzss_pkg;

    // Byte and length widths fixed by the stream format.
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned POS_W     = 12;
    localparam int unsigned LEN_W     = 5;
    localparam int unsigned MIN_MATCH = 3;

    // Flag byte handling: the upper byte marks that flag bits remain.
    localparam logic [7:0] FLAG_FILL = 8'hff;

    // Initial ring contents: spaces, with a zero tail.
    localparam logic [7:0] SPACE_BYTE = 8'h20;
    localparam logic [7:0] ZERO_BYTE  = 8'h00;

    // One compressed byte of the input stream.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_of_stream;
    } in_item_t;

    // One decompressed byte of the output stream.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } out_item_t;

    // Control from the parser to the history ring.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic restore;
    } ring_cmd_t;

endpackage

// File: rtl/core/lzss_ring.sv
module lzss_ring #(
    parameter int WINDOW_SIZE = 4096,
    parameter int MAX_MATCH   = 18,
    localparam int ADDR_W     = $clog2(WINDOW_SIZE)
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  lzss_pkg::ring_cmd_t       cmd,
    input  logic [ADDR_W-1:0]         rd_addr,
    input  logic [7:0]                wr_data,
    output logic [7:0]                rd_data
);

    localparam int                RESET_WP   = WINDOW_SIZE - MAX_MATCH;
    localparam logic [ADDR_W-1:0] RESET_ADDR = ADDR_W'(RESET_WP);
    localparam logic [ADDR_W:0]   FULL_FILL  = (ADDR_W + 1)'(WINDOW_SIZE);

    logic [7:0]        mem [WINDOW_SIZE];
    logic [7:0]        q_reg;
    logic              hit_reg;
    logic [7:0]        fwd_reg;
    logic              written_reg;
    logic              tail_reg;
    logic [ADDR_W-1:0] wp_reg;
    logic [ADDR_W-1:0] wp_next;
    logic [ADDR_W:0]   fill_reg;
    logic [ADDR_W:0]   fill_next;
    logic [ADDR_W-1:0] rd_offset;

    // Writes since the last restore cover a contiguous run starting at the
    // reset write position, so the offset from there tells whether an entry
    // holds live data or still carries its initial value.
    assign rd_offset = rd_addr - RESET_ADDR;

    // History memory, read-first, with a registered read.
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wp_reg] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            q_reg       <= mem[rd_addr];
            hit_reg     <= cmd.wr_en && (rd_addr == wp_reg);
            fwd_reg     <= wr_data;
            written_reg <= {1'b0, rd_offset} < fill_reg;
            tail_reg    <= rd_addr >= RESET_ADDR;
        end
    end

    // A byte written in the same cycle as it is read is forwarded; entries
    // never written since the restore read as their initial value.
    always_comb
    begin
        if (hit_reg)
        begin
            rd_data = fwd_reg;
        end
        else if (written_reg)
        begin
            rd_data = q_reg;
        end
        else if (tail_reg)
        begin
            rd_data = lzss_pkg::ZERO_BYTE;
        end
        else
        begin
            rd_data = lzss_pkg::SPACE_BYTE;
        end
    end

    // Write position and fill count; a restore takes priority.
    always_comb
    begin
        wp_next   = wp_reg;
        fill_next = fill_reg;
        if (cmd.restore)
        begin
            wp_next   = RESET_ADDR;
            fill_next = '0;
        end
        else if (cmd.wr_en)
        begin
            wp_next = wp_reg + 1'b1;
            if (fill_reg != FULL_FILL)
            begin
                fill_next = fill_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= RESET_ADDR;
            fill_reg <= '0;
        end
        else
        begin
            wp_reg   <= wp_next;
            fill_reg <= fill_next;
        end
    end

endmodule

// File: rtl/core/lzss_ctrl.sv
module lzss_ctrl #(
    parameter int ADDR_W    = 12,
    parameter int MAX_MATCH = 18
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  lzss_pkg::in_item_t    item,
    output logic                  result_valid,
    input  logic                  result_ready,
    output lzss_pkg::out_item_t   result,
    output lzss_pkg::ring_cmd_t   ring_cmd,
    output logic [ADDR_W-1:0]     ring_rd_addr,
    output logic [7:0]            ring_wr_data,
    input  logic [7:0]            ring_rd_data
);

    localparam int unsigned LEN_W = lzss_pkg::LEN_W;
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_MATCH);
    localparam logic [LEN_W-1:0] MIN_LEN = LEN_W'(lzss_pkg::MIN_MATCH);

    typedef enum logic [1:0] {
        ST_PARSE = 2'b01,
        ST_COPY  = 2'b10
    } state_t;

    state_t                 state_reg, state_next;
    logic [15:0]            flag_reg, flag_next;
    logic                   phase_reg, phase_next;
    logic [7:0]             low_reg, low_next;
    logic [ADDR_W-1:0]      src_reg, src_next;
    logic [LEN_W-1:0]       left_reg, left_next;
    logic                   copy_last_reg, copy_last_next;

    logic                   arr_valid_reg, arr_valid_next;
    logic                   arr_lit_reg, arr_lit_next;
    logic [7:0]             arr_byte_reg, arr_byte_next;
    logic                   arr_end_reg, arr_end_next;
    logic                   arr_restore_reg, arr_restore_next;

    lzss_pkg::out_item_t    fifo_reg [2];
    logic                   wr_ptr_reg;
    logic                   rd_ptr_reg;
    logic [1:0]             count_reg;
    logic                   push;
    logic                   pop;
    logic [2:0]             occupied;
    logic [2:0]             limit;
    logic                   space;
    logic                   accept;
    logic                   restore_now;
    logic [lzss_pkg::POS_W-1:0] pos;
    logic [LEN_W-1:0]       len_raw;
    logic [LEN_W-1:0]       len;
    lzss_pkg::out_item_t    push_item;

    // Room in the output queue for everything already in flight plus one.
    assign pop      = result_valid && result_ready;
    assign push     = arr_valid_reg;
    assign occupied = {1'b0, count_reg} + {2'b00, arr_valid_reg};
    assign limit    = 3'd2 + {2'b00, pop};
    assign space    = occupied < limit;

    assign item_ready = (state_reg == ST_PARSE) && space
                        && !(arr_valid_reg && arr_restore_reg);
    assign accept     = item_valid && item_ready;

    // Reference fields from the held low byte and the current byte.
    assign pos     = {item.in_byte[7:4], low_reg};
    assign len_raw = {1'b0, item.in_byte[3:0]} + MIN_LEN;
    assign len     = (len_raw > MAX_LEN) ? MAX_LEN : len_raw;

    // Arriving byte: a literal from the parser or a copy from the ring.
    assign ring_wr_data       = arr_lit_reg ? arr_byte_reg : ring_rd_data;
    assign push_item.out_byte    = ring_wr_data;
    assign push_item.last_of_run = arr_end_reg;

    // Parser and copy sequencer.
    always_comb
    begin
        state_next       = state_reg;
        flag_next        = flag_reg;
        phase_next       = phase_reg;
        low_next         = low_reg;
        src_next         = src_reg;
        left_next        = left_reg;
        copy_last_next   = copy_last_reg;
        arr_valid_next   = 1'b0;
        arr_lit_next     = 1'b0;
        arr_byte_next    = arr_byte_reg;
        arr_end_next     = 1'b0;
        arr_restore_next = 1'b0;
        restore_now      = 1'b0;
        ring_cmd.rd_en   = 1'b0;
        ring_rd_addr     = src_reg;

        unique case (state_reg)
            ST_PARSE:
            begin
                if (accept)
                begin
                    if (phase_reg)
                    begin
                        src_next       = ADDR_W'(pos);
                        left_next      = len;
                        copy_last_next = item.last_of_stream;
                        flag_next      = flag_reg >> 1;
                        phase_next     = 1'b0;
                        state_next     = ST_COPY;
                    end
                    else if (!flag_reg[8])
                    begin
                        flag_next   = {lzss_pkg::FLAG_FILL, item.in_byte};
                        restore_now = item.last_of_stream;
                    end
                    else if (flag_reg[0])
                    begin
                        arr_valid_next   = 1'b1;
                        arr_lit_next     = 1'b1;
                        arr_byte_next    = item.in_byte;
                        arr_end_next     = 1'b1;
                        arr_restore_next = item.last_of_stream;
                        flag_next        = flag_reg >> 1;
                    end
                    else
                    begin
                        low_next    = item.in_byte;
                        phase_next  = 1'b1;
                        restore_now = item.last_of_stream;
                    end

                    // The parser restarts at once; the ring follows its last write.
                    if (item.last_of_stream)
                    begin
                        flag_next  = '0;
                        phase_next = 1'b0;
                        low_next   = '0;
                    end
                end
            end
            ST_COPY:
            begin
                if (space)
                begin
                    ring_cmd.rd_en   = 1'b1;
                    arr_valid_next   = 1'b1;
                    arr_end_next     = (left_reg == LEN_W'(1));
                    arr_restore_next = (left_reg == LEN_W'(1)) && copy_last_reg;
                    src_next         = src_reg + 1'b1;
                    left_next        = left_reg - 1'b1;
                    if (left_reg == LEN_W'(1))
                    begin
                        state_next = ST_PARSE;
                    end
                end
            end
            default:
            begin
                state_next = ST_PARSE;
            end
        endcase

        ring_cmd.wr_en   = arr_valid_reg;
        ring_cmd.restore = restore_now || (arr_valid_reg && arr_restore_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_PARSE;
            flag_reg        <= '0;
            phase_reg       <= 1'b0;
            low_reg         <= '0;
            left_reg        <= '0;
            copy_last_reg   <= 1'b0;
            arr_valid_reg   <= 1'b0;
            arr_lit_reg     <= 1'b0;
            arr_end_reg     <= 1'b0;
            arr_restore_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            flag_reg        <= flag_next;
            phase_reg       <= phase_next;
            low_reg         <= low_next;
            left_reg        <= left_next;
            copy_last_reg   <= copy_last_next;
            arr_valid_reg   <= arr_valid_next;
            arr_lit_reg     <= arr_lit_next;
            arr_end_reg     <= arr_end_next;
            arr_restore_reg <= arr_restore_next;
        end
    end

    // Payload registers of the sequencer.
    always_ff @(posedge clk)
    begin
        src_reg      <= src_next;
        arr_byte_reg <= arr_byte_next;
    end

    // Two-entry output queue decoupling the ring from the result channel.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    assign result_valid = (count_reg != 2'd0);
    assign result       = fifo_reg[rd_ptr_reg];

endmodule

// File: rtl/core/lzss_stream_decoder_top.sv
// Latency: a literal beat passes the arrival register and the output queue on its
// way to the result channel; a reference enters its copy state in the cycle after
// its second byte. Throughput: one literal or flag byte a cycle while the output
// queue has room; a copy is paced by the single read port of the history memory.
// Reset restores everything at once, the history by a fill count; an end of stream
// that writes history restores with that write and holds the input while it does.
module lzss_stream_decoder_top #(
    parameter int WINDOW_SIZE = 4096,
    parameter int MAX_MATCH   = 18
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  lzss_pkg::in_item_t    item,
    output logic                  result_valid,
    input  logic                  result_ready,
    output lzss_pkg::out_item_t   result
);

    localparam int ADDR_W = $clog2(WINDOW_SIZE);

    lzss_pkg::ring_cmd_t ring_cmd;
    logic [ADDR_W-1:0]   ring_rd_addr;
    logic [7:0]          ring_wr_data;
    logic [7:0]          ring_rd_data;

    // Stream parser, copy sequencer and output queue.
    lzss_ctrl #(
        .ADDR_W    (ADDR_W),
        .MAX_MATCH (MAX_MATCH)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .ring_cmd     (ring_cmd),
        .ring_rd_addr (ring_rd_addr),
        .ring_wr_data (ring_wr_data),
        .ring_rd_data (ring_rd_data)
    );

    // History ring with write position and fill tracking.
    lzss_ring #(
        .WINDOW_SIZE (WINDOW_SIZE),
        .MAX_MATCH   (MAX_MATCH)
    ) u_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (ring_cmd),
        .rd_addr (ring_rd_addr),
        .wr_data (ring_wr_data),
        .rd_data (ring_rd_data)
    );

endmodule

// File: bench/lzss_checker.sv
module lzss_checker #(
    parameter int WINDOW_SIZE = 4096,
    parameter int MAX_MATCH   = 18
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  logic                item_ready,
    input  lzss_pkg::in_item_t  item,
    input  logic                result_valid,
    input  logic                result_ready,
    input  lzss_pkg::out_item_t result,
    output int unsigned         fail_count,
    output int unsigned         bytes_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    // Private copy of the decoder state.
    logic [7:0]  history [WINDOW_SIZE];
    int unsigned write_at;
    logic [15:0] marks;
    logic        ref_open;
    logic [7:0]  low_held;

    // Decompressed bytes predicted but not yet seen on the result channel.
    lzss_pkg::out_item_t bytes_due [$];
    int unsigned errors;

    // Put the ring and the parser back to their start-of-stream values.
    task automatic restore_stream();
        int i;
        for (i = 0; i < WINDOW_SIZE; i++)
        begin
            history[i] = (i >= WINDOW_SIZE - MAX_MATCH) ? lzss_pkg::ZERO_BYTE
                                                        : lzss_pkg::SPACE_BYTE;
        end
        write_at = WINDOW_SIZE - MAX_MATCH;
        marks    = '0;
        ref_open = 1'b0;
        low_held = '0;
    endtask

    // Queue one decompressed byte and record it in the history ring.
    task automatic emit_byte(input logic [7:0] b, input logic final_of_beat);
        lzss_pkg::out_item_t due;
        due.out_byte    = b;
        due.last_of_run = final_of_beat;
        bytes_due.push_back(due);
        history[write_at] = b;
        write_at = (write_at + 1) % WINDOW_SIZE;
    endtask

    // Work out the bytes that one compressed beat releases.
    task automatic decode_beat(input lzss_pkg::in_item_t beat);
        int unsigned src;
        int unsigned run_len;
        int unsigned k;
        if (ref_open)
        begin
            // Second byte of a reference: copy from the ring, one byte at a time,
            // so that a copy may read bytes it has only just written.
            src     = 32'({beat.in_byte[7:4], low_held});
            run_len = 32'(beat.in_byte[3:0]) + lzss_pkg::MIN_MATCH;
            if (run_len > MAX_MATCH)
            begin
                run_len = MAX_MATCH;
            end
            for (k = 0; k < run_len; k++)
            begin
                emit_byte(history[(src + k) % WINDOW_SIZE], k == run_len - 1);
            end
            marks    = marks >> 1;
            ref_open = 1'b0;
        end
        else if (!marks[8])
        begin
            // Flag byte: the upper half records that marks remain.
            marks = {lzss_pkg::FLAG_FILL, beat.in_byte};
        end
        else if (marks[0])
        begin
            emit_byte(beat.in_byte, 1'b1);
            marks = marks >> 1;
        end
        else
        begin
            low_held = beat.in_byte;
            ref_open = 1'b1;
        end

        // The end of a stream drops any unfinished token.
        if (beat.last_of_stream)
        begin
            restore_stream();
        end
    endtask

    // Check each result beat against the oldest prediction, then predict from
    // any input beat taken at the same edge.
    always @(posedge clk or negedge rst_n)
    begin
        lzss_pkg::out_item_t want;
        if (!rst_n)
        begin
            restore_stream();
            bytes_due.delete();
            errors = 0;
            fail_count <= 0;
            bytes_owed <= 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (bytes_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: result beat with none expected, got byte %02h last %0b",
                             $time, result.out_byte, result.last_of_run);
                end
                else
                begin
                    want = bytes_due.pop_front();
                    if (result.out_byte !== want.out_byte)
                    begin
                        errors++;
                        $display("%0t: out_byte expected %02h, got %02h",
                                 $time, want.out_byte, result.out_byte);
                    end
                    if (result.last_of_run !== want.last_of_run)
                    begin
                        errors++;
                        $display("%0t: last_of_run expected %0b, got %0b",
                                 $time, want.last_of_run, result.last_of_run);
                    end
                end
            end
            if (item_valid && item_ready)
            begin
                decode_beat(item);
            end
            fail_count <= errors;
            bytes_owed <= bytes_due.size();
        end
    end

endmodule

// File: bench/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WINDOW_SIZE    = 4096;
    localparam int MAX_MATCH      = 18;
    localparam int DIRECTED_BEATS = 24;
    localparam int RANDOM_BEATS   = 100;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 40;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                item_valid = 1'b0;
    logic                item_ready;
    lzss_pkg::in_item_t  item = '0;
    logic                result_valid;
    logic                result_ready = 1'b0;
    lzss_pkg::out_item_t result;

    int unsigned fail_count;
    int unsigned bytes_owed;
    int unsigned sent = 0;
    bit          calm = 1'b0;
    bit          hold_go = 1'b0;
    bit          held = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    lzss_stream_decoder_top #(
        .WINDOW_SIZE (WINDOW_SIZE),
        .MAX_MATCH   (MAX_MATCH)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    lzss_checker #(
        .WINDOW_SIZE (WINDOW_SIZE),
        .MAX_MATCH   (MAX_MATCH)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .fail_count   (fail_count),
        .bytes_owed   (bytes_owed)
    );

    // Offer one compressed beat, with the odd idle cycle in front of it, and
    // hold it until the decoder takes it.
    task automatic send_beat(input logic [7:0] b, input logic fin);
        while (!calm && $urandom_range(99) < 9)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= {b, fin};
        @(posedge clk);
        while (!item_ready)
        begin
            @(posedge clk);
        end
        sent++;
    endtask

    // One flag byte and its eight tokens with random content. Some streams are
    // closed cleanly, some are cut short anywhere, half run on into the next.
    task automatic send_random_stream();
        logic [7:0]  flags;
        logic [11:0] pos;
        logic [3:0]  len_code;
        logic [7:0]  seq [$];
        int unsigned t;
        int unsigned cut;
        flags = 8'($urandom);
        seq.push_back(flags);
        for (t = 0; t < 8; t++)
        begin
            if (flags[t])
            begin
                seq.push_back(8'($urandom));
            end
            else
            begin
                // A third of the references aim at the zero tail and the wrap.
                if ($urandom_range(2) == 0)
                begin
                    pos = 12'hfe0 + 12'($urandom_range(31));
                end
                else
                begin
                    pos = 12'($urandom);
                end
                len_code = 4'($urandom_range(15));
                seq.push_back(pos[7:0]);
                seq.push_back({pos[11:8], len_code});
            end
        end
        case ($urandom_range(3))
            0:       cut = $urandom_range(seq.size() - 1);
            1:       cut = seq.size() - 1;
            default: cut = seq.size();
        endcase
        for (t = 0; t < seq.size() && t <= cut; t++)
        begin
            send_beat(seq[t], t == cut);
        end
    endtask

    // Result side: random stalls, a quiet stretch, and one long hold-off so
    // that the decoder backs up into its input.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_go && !held)
            begin
                held = 1'b1;
                result_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            result_ready <= calm || ($urandom_range(99) >= 9);
        end
    end

    initial
    begin
        #1_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Stream with a literal, an overlapping full-length copy of it, a copy
        // that wraps the ring end, copies from the ring start, and a short one.
        send_beat(8'h05, 1'b0);
        send_beat(8'hff, 1'b0);
        send_beat(8'hee, 1'b0);
        send_beat(8'hff, 1'b0);
        send_beat(8'h00, 1'b0);
        send_beat(8'hff, 1'b0);
        send_beat(8'hf0, 1'b0);
        send_beat(8'h00, 1'b0);
        send_beat(8'h00, 1'b0);
        send_beat(8'h5a, 1'b0);
        send_beat(8'h3c, 1'b0);
        send_beat(8'h12, 1'b0);
        send_beat(8'ha7, 1'b0);
        send_beat(8'hf0, 1'b0);
        send_beat(8'h0f, 1'b0);
        // End of stream on a bare flag byte.
        send_beat(8'h00, 1'b1);
        // All literals, ending on a literal.
        send_beat(8'hff, 1'b0);
        send_beat(8'ha5, 1'b0);
        send_beat(8'h5a, 1'b1);
        // End of stream half way through a reference.
        send_beat(8'h00, 1'b0);
        send_beat(8'h33, 1'b1);
        // End of stream on the second byte of a reference into the zero tail.
        send_beat(8'h00, 1'b0);
        send_beat(8'hee, 1'b0);
        send_beat(8'hf5, 1'b1);

        // Let the decoder drain completely before the random part.
        item_valid <= 1'b0;
        @(posedge clk);
        while (bytes_owed != 0)
        begin
            @(posedge clk);
        end

        // Mostly well-formed streams, with bursts of stray bytes between them.
        while (sent < DIRECTED_BEATS + RANDOM_BEATS)
        begin
            calm <= (sent >= DIRECTED_BEATS + 40) && (sent < DIRECTED_BEATS + 80);
            if (sent >= DIRECTED_BEATS + 15)
            begin
                hold_go <= 1'b1;
            end
            if ($urandom_range(9) == 0)
            begin
                repeat ($urandom_range(1, 3)) send_beat(8'($urandom), $urandom_range(7) == 0);
            end
            else
            begin
                send_random_stream();
            end
        end

        item_valid <= 1'b0;
        @(posedge clk);
        while (bytes_owed != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && bytes_owed == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
